// ===== rtl/swrs_pkg.sv =====
// ----------------------------------------------------------------------------
// swrs_pkg
// Types and constants shared by the sliding-window rank-select filter:
// the controller states and the command and status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package swrs_pkg;

    localparam int SAMPLE_W = 32;  // width of one sample word
    localparam int CFG_W    = 7;   // width of a configuration register
    localparam int CFG_AW   = 1;   // width of the configuration index

    localparam logic [CFG_AW-1:0] CFG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_RANK_SELECT = 1'b1;

    localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 7'd64;
    localparam logic [CFG_W-1:0] RANK_SELECT_RST = 7'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_SELECT
    } t_state;

    typedef struct packed {
        logic load;    // capture the sample and read the oldest ring slot
        logic remove;  // drop one copy of the oldest value from the cells
        logic insert;  // insert the sample and advance the ring
        logic select;  // load the output register with the ranked cell
    } t_cmd;

    typedef struct packed {
        logic full;       // window already holds window_size samples
        logic will_fill;  // the sample being inserted fills the window
        logic out_free;   // output register can take a new word
    } t_status;

endpackage

// ===== rtl/swrs_ram.sv =====
// ----------------------------------------------------------------------------
// swrs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module swrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/swrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// swrs_ctrl
// Sequencer for one sample: capture, remove oldest, insert, select result.
// ----------------------------------------------------------------------------
module swrs_ctrl
    import swrs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_sts,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.full ? ST_REMOVE : ST_INSERT;
                end
            end
            ST_REMOVE: begin
                o_cmd.remove = 1'b1;
                n_state      = ST_INSERT;
            end
            ST_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = (i_sts.full || i_sts.will_fill) ? ST_SELECT : ST_IDLE;
            end
            ST_SELECT: begin
                // Hold here while the previous result still sits unread.
                if (i_sts.out_free) begin
                    o_cmd.select = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/swrs_datapath.sv =====
// ----------------------------------------------------------------------------
// swrs_datapath
// Sorted compare-shift cells, arrival ring, window counters, configuration
// registers and the output register.
// ----------------------------------------------------------------------------
module swrs_datapath
    import swrs_pkg::*;
#(
    parameter int WINDOW_MAX = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_AW-1:0]          i_cfg_addr,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  t_cmd                       i_cmd,
    output t_status                    o_sts,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_ranked_value
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int AW = $clog2(WINDOW_MAX);
    localparam int XW = (CW > CFG_W) ? CW : CFG_W;

    logic [CFG_W-1:0]           r_window_size;
    logic [CFG_W-1:0]           r_rank_select;
    logic [CW-1:0]              r_fill;
    logic [AW-1:0]              r_pos;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] r_cells [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] n_cells [WINDOW_MAX];
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data;

    logic [XW-1:0]              ws_ext;
    logic [XW-1:0]              rk_ext;
    logic [XW-1:0]              w_ext;
    logic [CW-1:0]              w_eff;
    logic [AW-1:0]              rank_idx;
    logic [CW-1:0]              ins_cnt;
    logic                       full;
    logic signed [SAMPLE_W-1:0] old_value;
    logic [SAMPLE_W-1:0]        ram_rdata;

    // A window of zero acts as one; anything past the cell count is clamped.
    always_comb begin
        ws_ext = XW'(r_window_size);
        if (ws_ext == '0) begin
            w_ext = XW'(1);
        end else if (ws_ext > XW'(WINDOW_MAX)) begin
            w_ext = XW'(WINDOW_MAX);
        end else begin
            w_ext = ws_ext;
        end
        w_eff = w_ext[CW-1:0];

        rk_ext = XW'(r_rank_select);
        if (rk_ext == '0) begin
            rk_ext = XW'(1);
        end
        if (rk_ext > w_ext) begin
            rk_ext = w_ext;
        end
        rank_idx = AW'(rk_ext - XW'(1));
    end

    assign full      = (r_fill == w_eff);
    assign ins_cnt   = full ? (w_eff - CW'(1)) : r_fill;
    assign old_value = $signed(ram_rdata);

    assign o_sts.full      = full;
    assign o_sts.will_fill = ((r_fill + CW'(1)) == w_eff);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    swrs_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.insert),
        .i_waddr (r_pos),
        .i_wdata (r_sample),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    // Each cell looks only at its neighbors. Removal pulls every cell at or
    // past the first copy of the oldest value one place down; since the
    // cells are sorted, that copy is the first cell not below the value.
    for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
        logic signed [SAMPLE_W-1:0] w_up;
        logic signed [SAMPLE_W-1:0] w_dn;
        logic                       dn_ok;
        logic                       keep;
        logic                       shr;

        if (gi < WINDOW_MAX - 1) begin : g_up
            assign w_up = r_cells[gi+1];
        end else begin : g_top
            assign w_up = r_cells[gi];
        end

        if (gi > 0) begin : g_dn
            assign w_dn  = r_cells[gi-1];
            assign dn_ok = (CW'(gi - 1) < ins_cnt) && (r_sample < w_dn);
        end else begin : g_bottom
            assign w_dn  = r_cells[gi];
            assign dn_ok = 1'b0;
        end

        assign keep = (CW'(gi) < ins_cnt) && !(r_sample < r_cells[gi]);
        assign shr  = dn_ok;

        always_comb begin
            n_cells[gi] = r_cells[gi];
            if (i_cmd.remove) begin
                if ((CW'(gi + 1) < w_eff) && (r_cells[gi] >= old_value)) begin
                    n_cells[gi] = w_up;
                end
            end else if (i_cmd.insert) begin
                if (keep) begin
                    n_cells[gi] = r_cells[gi];
                end else if (shr) begin
                    n_cells[gi] = w_dn;
                end else if (CW'(gi) <= ins_cnt) begin
                    n_cells[gi] = r_sample;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cells <= n_cells;
        if (i_cmd.load) begin
            r_sample <= i_sample_value;
        end
        if (i_cmd.select) begin
            r_out_data <= r_cells[rank_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_SIZE_RST;
            r_rank_select <= RANK_SELECT_RST;
            r_fill        <= '0;
            r_pos         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_addr == CFG_WINDOW_SIZE)) begin
                // A new window size starts the window over.
                r_window_size <= i_cfg_data;
                r_fill        <= '0;
                r_pos         <= '0;
            end else if (i_cmd.insert) begin
                if (!full) begin
                    r_fill <= r_fill + CW'(1);
                end
                if ((CW'(r_pos) + CW'(1)) >= w_eff) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + AW'(1);
                end
            end
            if (i_cfg_we && (i_cfg_addr == CFG_RANK_SELECT)) begin
                r_rank_select <= i_cfg_data;
            end
            if (i_cmd.select) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_ranked_value = r_out_data;

endmodule

// ===== rtl/sliding_window_rank_select_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_rank_select_core
// Running rank-order filter: reports the k-th smallest of the last N samples.
// ----------------------------------------------------------------------------
// Each sample word is inserted into a row of sorted compare-shift cells and
// into an arrival ring held in RAM. While the window fills, a sample is
// captured and inserted and produces no result; for the sample that fills
// the window, the ranked cell is then also copied out. Once the window is
// full, the oldest value is read from the ring RAM, one cell pass removes
// it, one cell pass inserts the new sample, and the ranked cell is copied
// into the output register. The input is stalled from capture until the
// sample is done, and longer while a previous result word sits unread.
// Writing the window size empties the window; ranks above it are clamped.
module sliding_window_rank_select_core
    import swrs_pkg::*;
#(
    parameter int WINDOW_MAX = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_AW-1:0]          i_cfg_addr,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_ranked_value
);

    t_cmd    cmd;
    t_status sts;

    swrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    swrs_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_sample_value (i_sample_value),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_ranked_value (o_ranked_value)
    );

endmodule

// ===== rtl/swrs_checker.sv =====
// ----------------------------------------------------------------------------
// swrs_checker
// Port-level checks on the rank-select filter, bound to the top level.
// ----------------------------------------------------------------------------
module swrs_checker
    import swrs_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic signed [SAMPLE_W-1:0] i_sample_value,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic signed [SAMPLE_W-1:0] o_ranked_value
);

    // A result word waiting on a stalled receiver stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_ranked_value)))
        else $error("result word changed or dropped while stalled");

    // A sample word offered to a stalled block stays put.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_sample_value)))
        else $error("sample word changed or dropped while stalled");

    // Every accepted sample keeps the block busy in the cycle after it is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted on consecutive cycles");

    // A new result only appears at the end of a sample's processing.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a sample in process");

    // Reset leaves the block idle with no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after reset");

endmodule

bind sliding_window_rank_select_core swrs_checker u_swrs_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sliding-window rank-select filter. A driver
// streams sample words from a queue, a scoreboard model of the sorted window
// predicts each ranked word, and a monitor checks every result word in order.
// Phases change the window and rank registers and the idle and stall rates.
// ----------------------------------------------------------------------------
module testbench;
    import swrs_pkg::*;

    localparam int WIN_MAX       = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 20000;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        bit                         drain_first;
    } t_sample_item;

    logic                       i_clk;
    logic                       i_rst_n        = 1'b0;
    logic                       i_cfg_we       = 1'b0;
    logic [CFG_AW-1:0]          i_cfg_addr     = '0;
    logic [CFG_W-1:0]           i_cfg_data     = '0;
    logic                       i_in_valid     = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample_value = '0;
    logic                       o_out_valid;
    logic                       i_out_stall    = 1'b0;
    logic signed [SAMPLE_W-1:0] o_ranked_value;

    sliding_window_rank_select_core #(
        .WINDOW_MAX(WIN_MAX)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample_value(i_sample_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_ranked_value(o_ranked_value)
    );

    t_sample_item               sample_q[$];
    logic signed [SAMPLE_W-1:0] ranked_q[$];
    int unsigned                send_idle_pct  = 0;
    int unsigned                recv_stall_pct = 0;
    int unsigned                fail_count     = 0;

    // Model of the window: ascending copies and arrival order.
    logic signed [SAMPLE_W-1:0] sorted_win[WIN_MAX];
    logic signed [SAMPLE_W-1:0] arrival_win[WIN_MAX];
    int unsigned                fill_cnt   = 0;
    int unsigned                oldest_pos = 0;
    logic [CFG_W-1:0]           win_reg    = WINDOW_SIZE_RST;
    logic [CFG_W-1:0]           rank_reg   = RANK_SELECT_RST;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    function automatic int unsigned active_window();
        if (win_reg < 1) begin
            return 1;
        end
        if (win_reg > WIN_MAX) begin
            return WIN_MAX;
        end
        return int'(win_reg);
    endfunction

    function automatic void sorted_insert(input logic signed [SAMPLE_W-1:0] x,
                                          input int unsigned count);
        int unsigned i;
        i = count;
        while (i > 0 && x < sorted_win[i-1]) begin
            sorted_win[i] = sorted_win[i-1];
            i--;
        end
        sorted_win[i] = x;
    endfunction

    // Drops the first copy of x; the top entry goes if x is not present.
    function automatic void sorted_remove(input logic signed [SAMPLE_W-1:0] x,
                                          input int unsigned count);
        int unsigned at;
        bit          found;
        at    = count - 1;
        found = 1'b0;
        for (int unsigned i = 0; i < count; i++) begin
            if (!found && sorted_win[i] == x) begin
                at    = i;
                found = 1'b1;
            end
        end
        for (int unsigned i = at; i + 1 < count; i++) begin
            sorted_win[i] = sorted_win[i+1];
        end
    endfunction

    task automatic predict_rank_step(input logic signed [SAMPLE_W-1:0] x,
                                     output bit has_word,
                                     output logic signed [SAMPLE_W-1:0] ranked);
        int unsigned w;
        int unsigned r;
        w = active_window();
        if (fill_cnt > w) begin
            fill_cnt = w;
        end
        if (oldest_pos >= w) begin
            oldest_pos = 0;
        end
        if (fill_cnt < w) begin
            sorted_insert(x, fill_cnt);
            fill_cnt++;
        end else begin
            sorted_remove(arrival_win[oldest_pos], w);
            sorted_insert(x, w - 1);
        end
        arrival_win[oldest_pos] = x;
        oldest_pos++;
        if (oldest_pos >= w) begin
            oldest_pos = 0;
        end
        has_word = (fill_cnt >= w);
        r = int'(rank_reg);
        if (r < 1) begin
            r = 1;
        end
        if (r > w) begin
            r = w;
        end
        ranked = sorted_win[r-1];
    endtask

    // Driver: presents queued sample words and predicts on each acceptance.
    always @(posedge i_clk) begin : drive_proc
        bit                         take_ok;
        bit                         has_word;
        logic signed [SAMPLE_W-1:0] ranked;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_rank_step(i_sample_value, has_word, ranked);
                if (has_word) begin
                    ranked_q.push_back(ranked);
                end
            end
            if (!i_in_valid || !o_in_stall) begin
                take_ok = (sample_q.size() != 0) &&
                          ($urandom_range(99) >= send_idle_pct);
                if (take_ok && sample_q[0].drain_first && ranked_q.size() != 0) begin
                    take_ok = 1'b0;
                end
                if (take_ok) begin
                    i_in_valid     <= 1'b1;
                    i_sample_value <= sample_q[0].sample;
                    void'(sample_q.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stall on the result side, in-order compare.
    always @(posedge i_clk) begin : check_proc
        logic signed [SAMPLE_W-1:0] want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (ranked_q.size() == 0) begin
                    note_failure($sformatf("unexpected result word: ranked_value %0d",
                                           o_ranked_value));
                end else begin
                    want = ranked_q.pop_front();
                    if (o_ranked_value !== want) begin
                        note_failure($sformatf(
                            "mismatch: ranked_value expected %0d, got %0d",
                            want, o_ranked_value));
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        if (idx == CFG_WINDOW_SIZE) begin
            win_reg    = val;
            fill_cnt   = 0;
            oldest_pos = 0;
        end else if (idx == CFG_RANK_SELECT) begin
            rank_reg = val;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits for a run of quiet cycles so samples with no result have settled.
    task automatic wait_idle();
        int unsigned quiet;
        quiet = 0;
        while (quiet < SETTLE_CYCLES) begin
            @(posedge i_clk);
            if (sample_q.size() == 0 && !i_in_valid && ranked_q.size() == 0) begin
                quiet++;
            end else begin
                quiet = 0;
            end
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            5, 6, 7: return $signed($urandom_range(15)) - 8;
            8: begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0;
                    default: return -32'sd1;
                endcase
            end
            9: return $signed($urandom_range(2)) - 1;
            default: return $urandom;
        endcase
    endfunction

    task automatic set_idling(input int unsigned pattern);
        case (pattern % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
        endcase
    endtask

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input bit drain);
        t_sample_item it;
        it.sample      = s;
        it.drain_first = drain;
        sample_q.push_back(it);
    endtask

    task automatic run_phase(input bit wr_win, input logic [CFG_W-1:0] win,
                             input bit wr_rank, input logic [CFG_W-1:0] rank,
                             input int unsigned n_items, input int unsigned pattern);
        wait_idle();
        if (wr_win) begin
            write_reg(CFG_WINDOW_SIZE, win);
        end
        if (wr_rank) begin
            write_reg(CFG_RANK_SELECT, rank);
        end
        set_idling(pattern);
        // Halfway through, the sender holds off until every word is back.
        for (int unsigned i = 0; i < n_items; i++) begin
            push_sample(rand_sample(), i == n_items / 2);
        end
    endtask

    initial begin : stim_proc
        logic signed [SAMPLE_W-1:0] directed[$];
        int unsigned                waited;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, duplicates that leave one copy, sign boundaries.
        write_reg(CFG_WINDOW_SIZE, 7'd4);
        write_reg(CFG_RANK_SELECT, 7'd2);
        set_idling(0);
        directed = {32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1,
                    32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                    32'sh8000_0000, 32'sh8000_0000, 32'sd5, 32'sd5, 32'sd5,
                    -32'sd5, 32'sd5, 32'sh8000_0000, 32'sh7fff_ffff, 32'sd1,
                    -32'sd1, 32'sd1, -32'sd1, 32'sh4000_0000, 32'shc000_0000,
                    32'sd7, 32'sd7};
        foreach (directed[i]) begin
            push_sample(directed[i], 1'b0);
        end

        run_phase(1'b1, 7'd1,   1'b1, 7'd1,   100, 1);
        run_phase(1'b1, 7'd0,   1'b1, 7'd0,   80,  2);
        run_phase(1'b1, 7'd127, 1'b1, 7'd127, 200, 3);
        run_phase(1'b1, 7'd64,  1'b1, 7'd64,  150, 0);
        // Rank change alone keeps the full window running.
        run_phase(1'b0, 7'd0,   1'b1, 7'd32,  100, 1);
        run_phase(1'b1, 7'd3,   1'b1, 7'd5,   120, 2);
        run_phase(1'b1, 7'd8,   1'b1, 7'd3,   150, 3);
        run_phase(1'b1, 7'd16,  1'b1, 7'd16,  150, 0);
        run_phase(1'b1, 7'd2,   1'b1, 7'd1,   100, 1);
        run_phase(1'b1, 7'd5,   1'b1, 7'd0,   100, 2);
        run_phase(1'b1, 7'd33,  1'b1, 7'd17,  150, 3);
        for (int unsigned p = 0; p < 3; p++) begin
            run_phase(1'b1, 7'($urandom_range(127)), 1'b1, 7'($urandom_range(127)),
                      50, p);
        end
        run_phase(1'b1, 7'd64, 1'b1, 7'd1, 100, 0);

        while (sample_q.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        waited = 0;
        while (ranked_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (ranked_q.size() != 0) begin
            note_failure($sformatf("%0d expected result words never arrived",
                                   ranked_q.size()));
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/swrs_pkg.sv
rtl/swrs_ram.sv
rtl/swrs_ctrl.sv
rtl/swrs_datapath.sv
rtl/sliding_window_rank_select_core.sv
rtl/swrs_checker.sv
tb/testbench.sv
